/* hw/rtl/ecrs_pkg.sv */
package ecrs_pkg;

	localparam int unsigned PRICE_W    = 32;
	localparam int unsigned ALPHA_W    = 17;
	localparam int unsigned PERIOD_W   = 7;
	localparam int unsigned RSI_W      = 15;
	localparam int unsigned MONEY_W    = 48;
	localparam int unsigned CHANGE_W   = 33;
	localparam int unsigned TOTAL_W    = 40;
	localparam int unsigned DIVIDEND_W = 64;
	localparam int unsigned DIVISOR_W  = 40;
	localparam int unsigned DIV_CNT_W  = 7;
	localparam int unsigned EMA_ACC_W  = 49;
	localparam int unsigned MUL_ACC_W  = 80;
	localparam int unsigned STEP_W     = 6;
	localparam int unsigned CFG_IDX_W  = 3;

	localparam logic [ALPHA_W-1:0]  Q_ONE       = 17'd65536;
	localparam logic [RSI_W-1:0]    RSI_FULL    = 15'd25600;
	localparam logic [RSI_W-1:0]    RSI_NEUTRAL = 15'd12800;
	localparam logic [MONEY_W-1:0]  MONEY_MAX   = 48'hFFFF_FFFF_FFFF;
	localparam logic [STEP_W-1:0]   EMA_STEPS   = 6'd17;
	localparam logic [STEP_W-1:0]   MUL_STEPS   = 6'd32;
	localparam logic [DIV_CNT_W-1:0] DIV_STEPS  = 7'd64;

	localparam logic [ALPHA_W-1:0]  RST_ALPHA_SHORT = 17'd9362;
	localparam logic [ALPHA_W-1:0]  RST_ALPHA_LONG  = 17'd3855;
	localparam logic [PERIOD_W-1:0] RST_RSI_PERIOD  = 7'd14;
	localparam logic [RSI_W-1:0]    RST_BUY_LIMIT   = 15'd17920;
	localparam logic [RSI_W-1:0]    RST_SELL_LIMIT  = 15'd7680;
	localparam logic [MONEY_W-1:0]  RST_START_CASH  = 48'd655360000;

	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_SHORT = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_LONG  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_RSI_PERIOD  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BUY_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SELL_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_START_CASH  = 3'd5;

	localparam logic [1:0] SIG_HOLD = 2'd0;
	localparam logic [1:0] SIG_BUY  = 2'd1;
	localparam logic [1:0] SIG_SELL = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EMA,
		ST_EMA_END,
		ST_PREP,
		ST_SUM,
		ST_RSI_GO,
		ST_RSI_WAIT,
		ST_DECIDE,
		ST_BUY_WAIT,
		ST_MUL_GO,
		ST_MUL,
		ST_FIN,
		ST_DONE
	} ecrs_state_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ecrs_div_stat_t;

endpackage

/* hw/rtl/ecrs_div.sv */
module ecrs_div import ecrs_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [DIVIDEND_W-1:0] dividend,
	input  logic [DIVISOR_W-1:0]  divisor,
	output ecrs_div_stat_t        stat,
	output logic [DIVIDEND_W-1:0] quotient
);

	logic [DIVIDEND_W-1:0] dq_q;
	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  dvs_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	assign trial = {rem_q, dq_q[DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_STEPS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			dq_q  <= {dq_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dq_q;

endmodule

/* hw/rtl/ema_crossover_rsi_signal.sv */
// EMA crossover signal with an RSI filter. One Q16.16 close price in, one result out.
// The block works on one price at a time. After the accepting cycle it runs the bit-serial average
// update and the setup states ST_EMA_END and ST_PREP; once the window is full it reads the change
// ring (one entry per cycle from its single read port) and, if a loss exists, runs the RSI division.
// Then come the decision state, on a buy at a nonzero price the share division, the bit-serial
// portfolio multiply and the result states ST_FIN and ST_DONE; it stays in ST_DONE while the
// result waits.
// Both divisions share one radix-2 restoring divider, one quotient
// bit per cycle. The change ring holds undefined data after reset; only entries
// written since reset are ever summed, so no clearing pass is needed.
module ema_crossover_rsi_signal import ecrs_pkg::*; #(
	parameter int unsigned WINDOW_MAX = 64
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [PRICE_W-1:0]    close_price,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [1:0]            trade_signal,
	output logic [PRICE_W-1:0]    short_average,
	output logic [PRICE_W-1:0]    long_average,
	output logic [RSI_W-1:0]      strength_index,
	output logic [MONEY_W-1:0]    portfolio_value,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [MONEY_W-1:0]    cfg_data
);

	localparam int unsigned RW = (WINDOW_MAX > 2) ? $clog2(WINDOW_MAX) : 1;
	localparam int unsigned SW = $clog2(WINDOW_MAX + 2);
	localparam int unsigned PW = $clog2(WINDOW_MAX + 1);

	ecrs_state_t state_q, state_d;

	logic [ALPHA_W-1:0]  alpha_short_q, alpha_long_q;
	logic [PERIOD_W-1:0] rsi_period_q;
	logic [RSI_W-1:0]    buy_limit_q, sell_limit_q;
	logic [MONEY_W-1:0]  start_cash_q;

	logic [PRICE_W-1:0]  price_q, last_q, short_q, long_q;
	logic                first_q;
	logic [SW-1:0]       seen_q;
	logic [RW-1:0]       ptr_q;
	logic [TOTAL_W-1:0]  gain_q, loss_q;
	logic [MONEY_W-1:0]  cash_q, shares_q, pv_q;
	logic [RSI_W-1:0]    rsi_q;
	logic [1:0]          sig_q;

	logic [STEP_W-1:0]   cnt_q;
	logic [ALPHA_W-1:0]  as_q, bs_q, al_q, bl_q;
	logic [EMA_ACC_W-1:0] acc_s_q, acc_l_q;
	logic [MONEY_W-1:0]  mcand_q;
	logic [PRICE_W-1:0]  mpl_q;
	logic [MUL_ACC_W-1:0] acc_m_q;

	logic signed [CHANGE_W-1:0] ring_mem [WINDOW_MAX];
	logic [RW-1:0]       rd_idx_q;
	logic [PW-1:0]       rd_cnt_q;
	logic signed [CHANGE_W-1:0] rd_data_s1;
	logic                rd_vld_s1;

	logic                out_valid_q;
	logic [1:0]          trade_signal_q;
	logic [PRICE_W-1:0]  short_out_q, long_out_q;
	logic [RSI_W-1:0]    rsi_out_q;
	logic [MONEY_W-1:0]  pv_out_q;

	logic                div_start;
	ecrs_div_stat_t      div_stat;
	logic [DIVIDEND_W-1:0] div_quot, div_dividend;
	logic [DIVISOR_W-1:0]  div_divisor;

	logic [ALPHA_W-1:0]  as_c, al_c;
	logic [8:0]          per_w;
	logic [PW-1:0]       period;
	logic                buy_c, sell_c, out_free, ema_fin;
	logic [RW-1:0]       ptr_next, ptr_prev, rd_prev;
	logic [CHANGE_W-1:0] neg_mag;
	logic [DIVIDEND_W-1:0] rsi_num;
	logic [MONEY_W-1:0]  mul_res;
	logic [MONEY_W:0]    pv_sum;

	assign as_c = (alpha_short_q > Q_ONE) ? Q_ONE : alpha_short_q;
	assign al_c = (alpha_long_q > Q_ONE) ? Q_ONE : alpha_long_q;

	always_comb begin
		per_w = {2'b00, rsi_period_q};
		if (per_w == 9'd0)
			per_w = 9'd1;
		if (per_w > 9'(WINDOW_MAX))
			per_w = 9'(WINDOW_MAX);
		period = PW'(per_w);
	end

	assign ptr_next = (ptr_q == RW'(WINDOW_MAX - 1)) ? '0 : ptr_q + 1'b1;
	assign ptr_prev = (ptr_q == '0) ? RW'(WINDOW_MAX - 1) : ptr_q - 1'b1;
	assign rd_prev  = (rd_idx_q == '0) ? RW'(WINDOW_MAX - 1) : rd_idx_q - 1'b1;
	assign neg_mag  = CHANGE_W'(-rd_data_s1);

	assign rsi_num = (DIVIDEND_W'(gain_q) << 14) + (DIVIDEND_W'(gain_q) << 13)
		+ (DIVIDEND_W'(gain_q) << 10);

	assign buy_c  = (short_q > long_q) && (rsi_q < buy_limit_q) && (shares_q == '0);
	assign sell_c = (short_q < long_q) && (rsi_q > sell_limit_q) && (shares_q != '0);

	assign mul_res = (acc_m_q[MUL_ACC_W-1:64] != '0) ? MONEY_MAX : acc_m_q[63:16];
	assign pv_sum  = {1'b0, cash_q} + {1'b0, mul_res};
	assign out_free = !out_valid_q || out_ready;
	assign ema_fin  = (cnt_q == 6'd1);

	assign div_dividend = (state_q == ST_RSI_GO) ? rsi_num : {cash_q, 16'h0000};
	assign div_divisor  = (state_q == ST_RSI_GO) ? DIVISOR_W'(gain_q + loss_q)
		: DIVISOR_W'(price_q);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (in_valid) state_d = ST_EMA;
			ST_EMA:      if (ema_fin) state_d = ST_EMA_END;
			ST_EMA_END:  state_d = ST_PREP;
			ST_PREP: begin
				if ((10'(seen_q) - 10'd1) < 10'(period))
					state_d = ST_DECIDE;
				else
					state_d = ST_SUM;
			end
			ST_SUM:      if (rd_cnt_q == '0 && !rd_vld_s1) state_d = ST_RSI_GO;
			ST_RSI_GO:   state_d = (loss_q == '0) ? ST_DECIDE : ST_RSI_WAIT;
			ST_RSI_WAIT: if (div_stat.done) state_d = ST_DECIDE;
			ST_DECIDE:   state_d = (buy_c && price_q != '0) ? ST_BUY_WAIT : ST_MUL_GO;
			ST_BUY_WAIT: if (div_stat.done) state_d = ST_MUL_GO;
			ST_MUL_GO:   state_d = ST_MUL;
			ST_MUL:      if (ema_fin) state_d = ST_FIN;
			ST_FIN:      state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready  = 1'b0;
		div_start = 1'b0;
		case (state_q)
			ST_IDLE:   in_ready = 1'b1;
			ST_RSI_GO: div_start = (loss_q != '0);
			ST_DECIDE: div_start = buy_c && (price_q != '0);
			default: begin
				in_ready  = 1'b0;
				div_start = 1'b0;
			end
		endcase
	end

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			alpha_short_q <= RST_ALPHA_SHORT;
			alpha_long_q  <= RST_ALPHA_LONG;
			rsi_period_q  <= RST_RSI_PERIOD;
			buy_limit_q   <= RST_BUY_LIMIT;
			sell_limit_q  <= RST_SELL_LIMIT;
			start_cash_q  <= RST_START_CASH;
			short_q       <= '0;
			long_q        <= '0;
			last_q        <= '0;
			seen_q        <= '0;
			ptr_q         <= '0;
			gain_q        <= '0;
			loss_q        <= '0;
			cash_q        <= RST_START_CASH;
			shares_q      <= '0;
			cnt_q         <= '0;
			rd_cnt_q      <= '0;
			rd_vld_s1     <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= (state_q == ST_SUM) && (rd_cnt_q != '0);
			case (state_q)
				ST_IDLE: if (in_valid) cnt_q <= EMA_STEPS;
				ST_EMA:  cnt_q <= cnt_q - 1'b1;
				ST_EMA_END: begin
					if (first_q) begin
						short_q <= price_q;
						long_q  <= price_q;
					end else begin
						short_q <= acc_s_q[47:16];
						long_q  <= acc_l_q[47:16];
						ptr_q   <= ptr_next;
					end
					last_q <= price_q;
					if (seen_q < SW'(WINDOW_MAX + 1))
						seen_q <= seen_q + 1'b1;
				end
				ST_PREP: begin
					rd_cnt_q <= period;
					gain_q   <= '0;
					loss_q   <= '0;
				end
				ST_SUM: begin
					if (rd_cnt_q != '0)
						rd_cnt_q <= rd_cnt_q - 1'b1;
					if (rd_vld_s1) begin
						if (!rd_data_s1[CHANGE_W-1])
							gain_q <= gain_q + TOTAL_W'(rd_data_s1[CHANGE_W-2:0]);
						else
							loss_q <= loss_q + TOTAL_W'(neg_mag);
					end
				end
				ST_DECIDE: begin
					if (buy_c) begin
						cash_q <= '0;
						if (price_q == '0)
							shares_q <= MONEY_MAX;
					end
				end
				ST_BUY_WAIT: begin
					if (div_stat.done)
						shares_q <= (div_quot[DIVIDEND_W-1:MONEY_W] != '0) ? MONEY_MAX
							: div_quot[MONEY_W-1:0];
				end
				ST_MUL_GO: cnt_q <= MUL_STEPS;
				ST_MUL:    cnt_q <= cnt_q - 1'b1;
				ST_FIN: begin
					if (sig_q == SIG_SELL) begin
						cash_q   <= mul_res;
						shares_q <= '0;
					end
				end
				default: ;
			endcase
			if (state_q == ST_DONE && out_free)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (cfg_valid) begin
				case (cfg_index)
					CFG_ALPHA_SHORT: alpha_short_q <= cfg_data[ALPHA_W-1:0];
					CFG_ALPHA_LONG:  alpha_long_q  <= cfg_data[ALPHA_W-1:0];
					CFG_RSI_PERIOD:  rsi_period_q  <= cfg_data[PERIOD_W-1:0];
					CFG_BUY_LIMIT:   buy_limit_q   <= cfg_data[RSI_W-1:0];
					CFG_SELL_LIMIT:  sell_limit_q  <= cfg_data[RSI_W-1:0];
					CFG_START_CASH: begin
						start_cash_q <= cfg_data;
						cash_q       <= cfg_data;
						shares_q     <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		rd_data_s1 <= ring_mem[rd_idx_q];
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					price_q <= close_price;
					first_q <= (seen_q == '0);
					as_q    <= as_c;
					bs_q    <= Q_ONE - as_c;
					al_q    <= al_c;
					bl_q    <= Q_ONE - al_c;
					acc_s_q <= '0;
					acc_l_q <= '0;
				end
			end
			ST_EMA: begin
				acc_s_q <= (acc_s_q << 1)
					+ (as_q[ALPHA_W-1] ? EMA_ACC_W'(price_q) : '0)
					+ (bs_q[ALPHA_W-1] ? EMA_ACC_W'(short_q) : '0);
				acc_l_q <= (acc_l_q << 1)
					+ (al_q[ALPHA_W-1] ? EMA_ACC_W'(price_q) : '0)
					+ (bl_q[ALPHA_W-1] ? EMA_ACC_W'(long_q) : '0);
				as_q <= as_q << 1;
				bs_q <= bs_q << 1;
				al_q <= al_q << 1;
				bl_q <= bl_q << 1;
			end
			ST_EMA_END: begin
				if (!first_q)
					ring_mem[ptr_q] <= $signed({1'b0, price_q}) - $signed({1'b0, last_q});
			end
			ST_PREP: rd_idx_q <= ptr_prev;
			ST_SUM:  if (rd_cnt_q != '0) rd_idx_q <= rd_prev;
			ST_RSI_GO: begin
				if (loss_q == '0)
					rsi_q <= RSI_FULL;
			end
			ST_RSI_WAIT: if (div_stat.done) rsi_q <= div_quot[RSI_W-1:0];
			ST_DECIDE: begin
				sig_q <= buy_c ? SIG_BUY : (sell_c ? SIG_SELL : SIG_HOLD);
			end
			ST_MUL_GO: begin
				mcand_q <= shares_q;
				mpl_q   <= price_q;
				acc_m_q <= '0;
			end
			ST_MUL: begin
				acc_m_q <= (acc_m_q << 1) + (mpl_q[PRICE_W-1] ? MUL_ACC_W'(mcand_q) : '0);
				mpl_q   <= mpl_q << 1;
			end
			ST_FIN: begin
				if (sig_q == SIG_SELL)
					pv_q <= mul_res;
				else
					pv_q <= pv_sum[MONEY_W] ? MONEY_MAX : pv_sum[MONEY_W-1:0];
			end
			ST_DONE: begin
				if (out_free) begin
					trade_signal_q <= sig_q;
					short_out_q    <= short_q;
					long_out_q     <= long_q;
					rsi_out_q      <= rsi_q;
					pv_out_q       <= pv_q;
				end
			end
			default: ;
		endcase
		if (state_q == ST_PREP && (10'(seen_q) - 10'd1) < 10'(period))
			rsi_q <= RSI_NEUTRAL;
	end

	ecrs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	assign out_valid       = out_valid_q;
	assign trade_signal    = trade_signal_q;
	assign short_average   = short_out_q;
	assign long_average    = long_out_q;
	assign strength_index  = rsi_out_q;
	assign portfolio_value = pv_out_q;

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_stat.busy) else $error("divider restarted while busy");

	a_rd_in_sum: assert property (@(posedge clk) disable iff (!arst_n)
		rd_vld_s1 |-> state_q == ST_SUM) else $error("ring read outside sum");

	a_start_cash: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_valid && cfg_index == CFG_START_CASH) |=> (cash_q == start_cash_q
		&& shares_q == '0)) else $error("starting cash not loaded");

endmodule

/* tb/sv/ecrs_checker.sv */
`timescale 1ns / 100ps
module ecrs_checker import ecrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  logic [PRICE_W-1:0]   close_price,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  logic [1:0]           trade_signal,
	input  logic [PRICE_W-1:0]   short_average,
	input  logic [PRICE_W-1:0]   long_average,
	input  logic [RSI_W-1:0]     strength_index,
	input  logic [MONEY_W-1:0]   portfolio_value,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [MONEY_W-1:0]   cfg_data,
	output int                   fail_count,
	output int                   pending
);
	typedef struct packed {
		logic [1:0]         sig;
		logic [PRICE_W-1:0] s_avg;
		logic [PRICE_W-1:0] l_avg;
		logic [RSI_W-1:0]   rsi;
		logic [MONEY_W-1:0] value;
	} signal_t;

	localparam int WMAX = 64;

	signal_t expected_signals[$];
	logic [16:0] a_short, a_long;
	logic [6:0]  period_reg;
	logic [14:0] buy_lim, sell_lim;
	logic [47:0] start_cash;
	logic [31:0] sh_avg, lg_avg, prev_price;
	int          seen;
	longint      changes[WMAX];
	int          wr_ptr;
	logic [47:0] cash, shares;

	function automatic logic [31:0] ema(logic [16:0] a, logic [31:0] p, logic [31:0] prv);
		logic [63:0] w;
		w = (a > Q_ONE) ? 64'(Q_ONE) : 64'(a);
		return 32'((w * p + (64'd65536 - w) * prv) >> 16);
	endfunction

	function automatic logic [47:0] scale_sat(logic [47:0] q, logic [31:0] p);
		logic [127:0] m;
		m = (128'(q) * p) >> 16;
		return (m > 128'(MONEY_MAX)) ? MONEY_MAX : m[47:0];
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
		fail_count++;
	endtask

	task automatic predict_price(input logic [31:0] p);
		int per, n;
		longint c;
		logic [63:0] g, l, rsi;
		logic [127:0] q;
		logic [1:0] sig;
		logic [127:0] v;
		signal_t e;
		if (seen == 0) begin
			sh_avg = p;
			lg_avg = p;
		end else begin
			sh_avg = ema(a_short, p, sh_avg);
			lg_avg = ema(a_long, p, lg_avg);
			changes[wr_ptr] = longint'({32'd0, p}) - longint'({32'd0, prev_price});
			wr_ptr = (wr_ptr + 1) % WMAX;
		end
		prev_price = p;
		if (seen < WMAX + 1)
			seen++;
		per = (period_reg == 0) ? 1 : int'(period_reg);
		if (per > WMAX)
			per = WMAX;
		if (seen - 1 < per) begin
			rsi = 64'(RSI_NEUTRAL);
		end else begin
			g = 0;
			l = 0;
			for (n = 1; n <= per; n++) begin
				c = changes[(wr_ptr + WMAX - n) % WMAX];
				if (c > 0)
					g += c;
				else
					l += -c;
			end
			rsi = (l == 0) ? 64'(RSI_FULL) : (64'(RSI_FULL) * g) / (g + l);
		end
		sig = SIG_HOLD;
		if (sh_avg > lg_avg && rsi < buy_lim && shares == 0) begin
			if (p == 0) begin
				shares = MONEY_MAX;
			end else begin
				q = (128'(cash) << 16) / p;
				shares = (q > 128'(MONEY_MAX)) ? MONEY_MAX : q[47:0];
			end
			cash = 0;
			sig = SIG_BUY;
		end else if (sh_avg < lg_avg && rsi > sell_lim && shares > 0) begin
			cash = scale_sat(shares, p);
			shares = 0;
			sig = SIG_SELL;
		end
		v = 128'(cash) + scale_sat(shares, p);
		e.sig = sig;
		e.s_avg = sh_avg;
		e.l_avg = lg_avg;
		e.rsi = rsi[14:0];
		e.value = (v > 128'(MONEY_MAX)) ? MONEY_MAX : v[47:0];
		expected_signals.insert(expected_signals.size(), e);
	endtask

	always @(posedge clk or negedge arst_n) begin
		signal_t e;
		if (!arst_n) begin
			a_short = RST_ALPHA_SHORT;
			a_long = RST_ALPHA_LONG;
			period_reg = RST_RSI_PERIOD;
			buy_lim = RST_BUY_LIMIT;
			sell_lim = RST_SELL_LIMIT;
			start_cash = RST_START_CASH;
			cash = RST_START_CASH;
			shares = 0;
			sh_avg = 0;
			lg_avg = 0;
			prev_price = 0;
			seen = 0;
			wr_ptr = 0;
			expected_signals.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ALPHA_SHORT: a_short = cfg_data[16:0];
					CFG_ALPHA_LONG:  a_long = cfg_data[16:0];
					CFG_RSI_PERIOD:  period_reg = cfg_data[6:0];
					CFG_BUY_LIMIT:   buy_lim = cfg_data[14:0];
					CFG_SELL_LIMIT:  sell_lim = cfg_data[14:0];
					CFG_START_CASH: begin
						start_cash = cfg_data;
						cash = cfg_data;
						shares = 0;
					end
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_signals.size() == 0) begin
					report("unexpected result", 0, 0);
				end else begin
					e = expected_signals.pop_front();
					if (trade_signal !== e.sig)
						report("trade_signal", trade_signal, e.sig);
					if (short_average !== e.s_avg)
						report("short_average", short_average, e.s_avg);
					if (long_average !== e.l_avg)
						report("long_average", long_average, e.l_avg);
					if (strength_index !== e.rsi)
						report("strength_index", strength_index, e.rsi);
					if (portfolio_value !== e.value)
						report("portfolio_value", portfolio_value, e.value);
				end
			end
			if (in_valid && in_ready)
				predict_price(close_price);
			pending = expected_signals.size();
		end
	end
endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 100ps
module tb_top;
	import ecrs_pkg::*;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_ready;
	logic [PRICE_W-1:0]   close_price;
	logic                 out_valid;
	logic                 out_ready;
	logic [1:0]           trade_signal;
	logic [PRICE_W-1:0]   short_average;
	logic [PRICE_W-1:0]   long_average;
	logic [RSI_W-1:0]     strength_index;
	logic [MONEY_W-1:0]   portfolio_value;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [MONEY_W-1:0]   cfg_data;
	int                   fail_count;
	int                   pending;
	int                   cycle_count;
	logic                 long_hold;
	logic [31:0]          walk_price;

	localparam int CYCLE_LIMIT = 3000000;

	ema_crossover_rsi_signal dut (.*);

	ecrs_checker checker_i (.*);

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	initial begin
		arst_n = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_count <= 0;
		end else begin
			cycle_count <= cycle_count + 1;
			if (cycle_count > CYCLE_LIMIT) begin
				$display("FAILURE");
				$finish;
			end
		end
	end

	// receiver: random stalls, long hold-offs on request
	initial begin
		int k;
		out_ready = 0;
		long_hold = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 0;
				for (k = 0; k < 3000; k++)
					@(posedge clk);
				long_hold = 0;
			end
			case ($urandom_range(0, 3))
				0: out_ready <= 1;
				1: out_ready <= ($urandom_range(0, 3) != 0);
				2: out_ready <= ($urandom_range(0, 1) != 0);
				default: out_ready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [MONEY_W-1:0] val);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
	endtask

	task automatic settle;
		while (pending != 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic send_price(input logic [31:0] p);
		in_valid <= 1;
		close_price <= p;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic gap;
		int g;
		in_valid <= 0;
		g = $urandom_range(0, 3);
		if (g == 0)
			g = $urandom_range(1, 30);
		else
			g = 0;
		repeat (g) @(posedge clk);
	endtask

	task automatic random_setting(input int mode);
		logic [16:0] a1, a2;
		case (mode)
			0: begin a1 = 17'd0; a2 = 17'h1FFFF; end
			1: begin a1 = 17'd65536; a2 = 17'd0; end
			default: begin
				a1 = 17'($urandom_range(0, 70000));
				a2 = 17'($urandom_range(0, 70000));
			end
		endcase
		write_reg(CFG_ALPHA_SHORT, 48'(a1));
		write_reg(CFG_ALPHA_LONG, 48'(a2));
		write_reg(CFG_RSI_PERIOD, 48'((mode == 0) ? 7'd0 : (mode == 1) ? 7'd127 :
			7'($urandom_range(1, 64))));
		write_reg(CFG_BUY_LIMIT,
			48'((mode == 0) ? 15'h7FFF : 15'($urandom_range(0, 25600))));
		write_reg(CFG_SELL_LIMIT,
			48'((mode == 1) ? 15'd0 : 15'($urandom_range(0, 25600))));
		write_reg(CFG_START_CASH, (mode == 0) ? MONEY_MAX :
			(mode == 1) ? 48'd0 : 48'({$urandom, $urandom}));
	endtask

	initial begin
		int n, phase, burst;
		logic [31:0] p;
		in_valid = 0;
		close_price = 0;
		cfg_valid = 0;
		cfg_index = 0;
		cfg_data = 0;
		@(posedge arst_n);
		@(posedge clk);
		// directed: extremes, ramp up, ramp down, zero price
		send_price(32'hFFFF_FFFF);
		send_price(32'd1);
		send_price(32'd0);
		for (n = 0; n < 8; n++) send_price(32'h0001_0000 * (n + 1));
		for (n = 0; n < 8; n++) send_price(32'h0010_0000 - 32'h0001_0000 * n);
		send_price(32'hAAAA_5555);
		send_price(32'h5555_AAAA);
		in_valid <= 0;
		settle();
		for (phase = 0; phase < 8; phase++) begin
			random_setting(phase);
			walk_price = $urandom_range(1, 32'h00FF_FFFF);
			n = 0;
			while (n < 175) begin
				burst = $urandom_range(1, 20);
				repeat (burst) begin
					case ($urandom_range(0, 9))
						0: p = $urandom;
						1: p = 32'hFFFF_FFFF - $urandom_range(0, 3);
						2: p = $urandom_range(0, 2);
						default: begin
							walk_price = walk_price + $urandom_range(0, 32'h0004_0000)
								- 32'h0002_0000;
							p = walk_price;
						end
					endcase
					send_price(p);
					n++;
				end
				gap();
				if (phase == 3 && n > 60 && n < 90)
					long_hold = 1;
			end
			in_valid <= 0;
			settle();
		end
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end
endmodule

/* sim.f */
hw/rtl/ecrs_pkg.sv
hw/rtl/ecrs_div.sv
hw/rtl/ema_crossover_rsi_signal.sv
tb/sv/ecrs_checker.sv
tb/sv/tb_top.sv
